// ===== src/amr_cma_pkg.sv =====
// Shared constants and types for the amr codec mode adaptation block.
// Holds the field widths, decision codes and register indexes.
// No dependencies.
package amr_cma_pkg;

	// input and result field widths
	localparam int unsigned CI_W    = 11;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned DEC_W   = 2;
	localparam int unsigned THR_W   = 6;
	localparam int unsigned HYS_W   = 4;
	localparam int unsigned CC_W    = 3;
	localparam int unsigned CFG_W   = 6;
	localparam int unsigned CFG_A_W = 3;
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 16;
	// compare width for the average against scaled thresholds
	localparam int unsigned CMP_W   = 12;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [DEC_W-1:0]  dec_t;

	// decision codes
	localparam dec_t DEC_ACCUM   = 2'd0;
	localparam dec_t DEC_KEPT    = 2'd1;
	localparam dec_t DEC_DEGRADE = 2'd2;
	localparam dec_t DEC_UPGRADE = 2'd3;

	// configuration register indexes
	localparam logic [CFG_A_W-1:0] REG_HALF_RATE   = 3'd0;
	localparam logic [CFG_A_W-1:0] REG_CODEC_COUNT = 3'd1;
	localparam logic [CFG_A_W-1:0] REG_THR0        = 3'd2;
	localparam logic [CFG_A_W-1:0] REG_THR1        = 3'd3;
	localparam logic [CFG_A_W-1:0] REG_THR2        = 3'd4;
	localparam logic [CFG_A_W-1:0] REG_HYS0        = 3'd5;
	localparam logic [CFG_A_W-1:0] REG_HYS1        = 3'd6;
	localparam logic [CFG_A_W-1:0] REG_HYS2        = 3'd7;

	localparam logic [CC_W-1:0] CODEC_COUNT_RST = 3'd4;
	localparam logic [CC_W-1:0] CODEC_COUNT_MAX = 3'd4;
	localparam mode_t           MODE_TOP        = 2'd3;

endpackage

// ===== src/amr_codec_mode_adaptation.sv =====
// AMR codec mode adaptation: C/I averaging and codec mode request.
// Uses amr_cma_pkg for widths, decision codes and register indexes.
// One shared restoring divider step unit under a small sequencer.
//
// Usage:
//   s_tdata carries one uplink block measurement per beat (C/I in
//   centibels and the used codec mode). m_tdata carries one result per
//   input beat: the requested mode, the decision and the average.
//   Configuration is written through cfg_we/cfg_index/cfg_data; the user
//   must do so only while idle, as the block itself does not enforce it.
//   An item that does not evaluate gives its result in the cycle after
//   acceptance. An evaluating item loads the divider on acceptance, which
//   then gives one quotient bit per cycle for the SUM_W-bit dividend
//   (SUM_W = clog2(COUNT_LIMIT+1) + 11, 23 at the default limit); a decide
//   state then sets the result. The block takes one item at a time; s_tready
//   is high in idle while the result register is empty or being drained.
// Reset:
//   arst_n clears the sum, count and requested mode, sets codec_count
//   to 4 and other config registers to 0, and empties the result register.
// Stall:
//   A result holds on m_tdata until m_tready; no new item is taken
//   until that result leaves.
module amr_codec_mode_adaptation
	import amr_cma_pkg::*;
#(
	parameter int unsigned MIN_SAMPLES = 48,
	parameter int unsigned COUNT_LIMIT = 4095
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave: [10:0] ci_centibel, [12:11] used_mode, [15:13] zero
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// master: [1:0] requested_mode, [3:2] decision, [14:4] average_ci, [15] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_A_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int unsigned CNT_W  = $clog2(COUNT_LIMIT + 1);
	localparam int unsigned SUM_W  = CNT_W + CI_W;
	localparam int unsigned ITER_W = $clog2(SUM_W + 1);

	localparam logic [CNT_W:0]    LIMIT_EXT = (CNT_W + 1)'(COUNT_LIMIT);
	localparam logic [CNT_W:0]    MIN_EXT   = (CNT_W + 1)'(MIN_SAMPLES);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0] state_q;

	// configuration registers
	logic             half_rate_q;
	logic [CC_W-1:0]  codec_count_q;
	logic [THR_W-1:0] thr0_q, thr1_q, thr2_q;
	logic [HYS_W-1:0] hys0_q, hys1_q, hys2_q;

	// running state
	mode_t                   req_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;

	// divider registers
	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  rem_q;
	logic              neg_q;
	logic [ITER_W-1:0] iter_q;

	// result register
	logic            out_valid_q;
	mode_t           out_mode_q;
	dec_t            out_dec_q;
	logic [CI_W-1:0] out_avg_q;

	// input fields
	logic signed [CI_W-1:0] ci;
	mode_t                  used_mode;
	assign ci        = s_tdata[CI_W-1:0];
	assign used_mode = s_tdata[CI_W +: MODE_W];

	logic accept;
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// accumulate with weight and count limit
	logic [CNT_W:0]          cnt_try;
	logic                    fits;
	logic signed [SUM_W-1:0] ci_w;
	logic [CNT_W-1:0]        cnt_new;
	logic signed [SUM_W-1:0] sum_new;
	logic                    eval;

	always_comb begin
		cnt_try = {1'b0, count_q} + (half_rate_q ? (CNT_W + 1)'(2) : (CNT_W + 1)'(1));
		fits    = cnt_try <= LIMIT_EXT;
		ci_w    = half_rate_q ? (SUM_W'(ci) <<< 1) : SUM_W'(ci);
		cnt_new = fits ? cnt_try[CNT_W-1:0] : count_q;
		sum_new = fits ? (sum_q + ci_w) : sum_q;
		eval    = (used_mode == req_q) && ({1'b0, cnt_new} >= MIN_EXT);
	end

	// one restoring division step
	logic [CNT_W:0] trial;
	logic           q_bit;
	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]} - {1'b0, dvs_q};
		q_bit = !trial[CNT_W];
	end

	// signed average and scaled thresholds
	logic [CI_W-1:0]         q_mag;
	logic signed [CMP_W-1:0] avg;
	logic [THR_W-1:0]        thr_lo, thr_cur;
	logic [HYS_W-1:0]        hys_cur;
	logic signed [CMP_W-1:0] lim_lo, lim_hi;
	logic [CC_W-1:0]         top;
	logic                    degrade, upgrade;

	always_comb begin
		q_mag = dvd_q[CI_W-1:0];
		avg   = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		case (req_q)
			2'd1:    thr_lo = thr0_q;
			2'd2:    thr_lo = thr1_q;
			2'd3:    thr_lo = thr2_q;
			default: thr_lo = '0;
		endcase
		case (req_q)
			2'd0:    begin thr_cur = thr0_q; hys_cur = hys0_q; end
			2'd1:    begin thr_cur = thr1_q; hys_cur = hys1_q; end
			2'd2:    begin thr_cur = thr2_q; hys_cur = hys2_q; end
			default: begin thr_cur = '0;     hys_cur = '0;     end
		endcase
		lim_lo  = $signed(CMP_W'(thr_lo) * CMP_W'(5));
		lim_hi  = $signed((CMP_W'(thr_cur) + CMP_W'(hys_cur)) * CMP_W'(5));
		top     = (codec_count_q > CODEC_COUNT_MAX) ? CODEC_COUNT_MAX : codec_count_q;
		degrade = (req_q != '0) && (avg < lim_lo);
		upgrade = (top >= CC_W'(1)) && ((CC_W'(req_q) + CC_W'(1)) < top)
			&& (req_q < MODE_TOP) && (avg > lim_hi);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_rate_q   <= 1'b0;
			codec_count_q <= CODEC_COUNT_RST;
			thr0_q        <= '0;
			thr1_q        <= '0;
			thr2_q        <= '0;
			hys0_q        <= '0;
			hys1_q        <= '0;
			hys2_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HALF_RATE:   half_rate_q   <= cfg_data[0];
				REG_CODEC_COUNT: codec_count_q <= cfg_data[CC_W-1:0];
				REG_THR0:        thr0_q        <= cfg_data[THR_W-1:0];
				REG_THR1:        thr1_q        <= cfg_data[THR_W-1:0];
				REG_THR2:        thr2_q        <= cfg_data[THR_W-1:0];
				REG_HYS0:        hys0_q        <= cfg_data[HYS_W-1:0];
				REG_HYS1:        hys1_q        <= cfg_data[HYS_W-1:0];
				REG_HYS2:        hys2_q        <= cfg_data[HYS_W-1:0];
				default:         ;
			endcase
		end
	end

	// sequencer, accumulator and requested mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (eval) begin
							count_q     <= '0;
							sum_q       <= '0;
							iter_q      <= '0;
							out_valid_q <= 1'b0;
							state_q     <= ST_DIV;
						end else begin
							count_q     <= cnt_new;
							sum_q       <= sum_new;
							out_valid_q <= 1'b1;
						end
					end else if (m_tready) begin
						// result beat leaves with no new item behind it
						out_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_LAST)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (degrade)
						req_q <= req_q - mode_t'(1);
					else if (upgrade)
						req_q <= req_q + mode_t'(1);
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					neg_q <= sum_new < 0;
					dvd_q <= (sum_new < 0) ? SUM_W'(-sum_new) : SUM_W'(sum_new);
					dvs_q <= cnt_new;
					rem_q <= '0;
					if (!eval) begin
						out_mode_q <= req_q;
						out_dec_q  <= DEC_ACCUM;
						out_avg_q  <= '0;
					end
				end
			end
			ST_DIV: begin
				rem_q <= q_bit ? trial[CNT_W-1:0] : {rem_q[CNT_W-2:0], dvd_q[SUM_W-1]};
				dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
			end
			ST_DECIDE: begin
				out_avg_q <= avg[CI_W-1:0];
				if (degrade) begin
					out_mode_q <= req_q - mode_t'(1);
					out_dec_q  <= DEC_DEGRADE;
				end else if (upgrade) begin
					out_mode_q <= req_q + mode_t'(1);
					out_dec_q  <= DEC_UPGRADE;
				end else begin
					out_mode_q <= req_q;
					out_dec_q  <= DEC_KEPT;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_avg_q, out_dec_q, out_mode_q});

endmodule
